/* hdl/slfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfe_pkg
// Types and constants shared by the sync/length frame extractor.
// ----------------------------------------------------------------------------
package slfe_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hE2;
   localparam logic [7:0] SYNC_SECOND = 8'h98;
   localparam logic [7:0] SYNC_THIRD  = 8'hA2;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_SYNC1   = 3'd1,
      PH_SYNC2   = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_LEN_LO  = 3'd4,
      PH_PAYLOAD = 3'd5
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
      logic       empty;
   } result_type;

endpackage

/* hdl/slfe_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfe_parser
// Header parser: sync hunt, length capture and payload byte countdown.
// Produces the result for the byte on rx_byte; state advances on take.
// ----------------------------------------------------------------------------
module slfe_parser import slfe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] rx_byte,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [15:0] length;
   phase_type   restart;

   assign length  = {length_high_ff, rx_byte};
   assign restart = (rx_byte == SYNC_FIRST) ? PH_SYNC1 : PH_HUNT;

   // next state
   always_comb begin
      phase_in       = phase_ff;
      length_high_in = length_high_ff;
      bytes_left_in  = bytes_left_ff;
      case (phase_ff)
         PH_SYNC1: begin
            phase_in = (rx_byte == SYNC_SECOND) ? PH_SYNC2 : restart;
         end
         PH_SYNC2: begin
            phase_in = (rx_byte == SYNC_THIRD) ? PH_LEN_HI : restart;
         end
         PH_LEN_HI: begin
            length_high_in = rx_byte;
            phase_in       = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            bytes_left_in = length;
            phase_in      = (length == 16'd0) ? PH_HUNT : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            if (bytes_left_ff != 16'd0) begin
               bytes_left_in = bytes_left_ff - 16'd1;
               if (bytes_left_ff == 16'd1) begin
                  phase_in = PH_HUNT;
               end
            end else begin
               phase_in = restart;
            end
         end
         default: begin
            phase_in = restart;
         end
      endcase
   end

   // result
   always_comb begin
      result = '0;
      case (phase_ff)
         PH_LEN_LO: begin
            if (length == 16'd0) begin
               result.valid = 1'b1;
               result.last  = 1'b1;
               result.empty = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            result.valid = (bytes_left_ff != 16'd0);
            result.data  = rx_byte;
            result.last  = (bytes_left_ff == 16'd1);
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         length_high_ff <= 8'd0;
         bytes_left_ff  <= 16'd0;
      end else if (take) begin
         phase_ff       <= phase_in;
         length_high_ff <= length_high_in;
         bytes_left_ff  <= bytes_left_in;
      end
   end

endmodule

/* hdl/sync_length_frame_extractor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_frame_extractor_unit
// Deframer for a byte stream: finds sync E2 98 A2, reads a 16-bit
// big-endian length and forwards the payload bytes, tagging the last one.
// ----------------------------------------------------------------------------
//  channel | dir | tdata           | tlast       | tuser
//  req     | in  | rx_byte[7:0]    | -           | -
//  rsp     | out | payload_byte    | frame_last  | frame_empty
//
//  One byte per cycle while req_tready is high; a result shows the cycle after its byte.
//  The only limit is the single output register: req_tready drops only
//  while a result waits and rsp_tready is low.
//  Synchronous active-high reset returns the parser to sync hunt.
// ----------------------------------------------------------------------------
module sync_length_frame_extractor_unit import slfe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] payload_byte
   output logic       rsp_tlast,   // frame_last
   output logic       rsp_tuser    // [0] frame_empty
);

   result_type result;
   logic       accept;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff;
   logic       rsp_last_ff;
   logic       rsp_empty_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   slfe_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (accept),
      .rx_byte (req_tdata),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = result.valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff  <= result.data;
         rsp_last_ff  <= result.last;
         rsp_empty_ff <= result.empty;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_empty_ff;

endmodule
